FILE: sv/first_fit_free_list_allocator_top_macros.svh
// Assertion macros for the first-fit free-list allocator.
// Used by the controller and the top level; no other dependencies.
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define FFA_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define FFA_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define FFA_ASSERT_IMPL(label, clk, rst, prop)
`define FFA_ASSERT_NORST(label, clk, prop)
`endif
`endif

FILE: sv/ffa_pkg.sv
// Shared types and constants for the first-fit free-list allocator.
// No dependencies.
package ffa_pkg;
   localparam logic [31:0] PAGE_MASK_LOW  = 32'h0000_0fff;
   localparam logic [31:0] PAGE_MASK_HIGH = 32'hffff_f000;
   localparam logic [31:0] TOP_ADDRESS    = 32'hffff_ffff;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOFIT   = 2'd1,
      ST_LOST    = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_A_RD,
      S_A_CHK,
      S_R_CHK,
      S_R_WR,
      S_F_RD,
      S_F_CHK,
      S_F_DECIDE,
      S_I_CHK,
      S_I_WR,
      S_I_NEW,
      S_RESP
   } state_type;

   // Controller to datapath commands.
   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_RD_IDX,
      CMD_IDX_INC,
      CMD_ALLOC_WR,
      CMD_NOFIT,
      CMD_SAVE_PREV,
      CMD_SAVE_NEXT,
      CMD_MERGE_PREV,
      CMD_MERGE_BOTH,
      CMD_MERGE_NEXT,
      CMD_INS_SETUP,
      CMD_INS_RD,
      CMD_INS_WR,
      CMD_INS_NEW,
      CMD_REM_RD,
      CMD_REM_WR,
      CMD_REM_DONE,
      CMD_LOST
   } cmd_type;

   typedef struct packed {
      logic       is_free;
      logic       size_zero;
      logic       idx_lt_cnt;
      logic       fits;
      logic       len_zero;
      logic       start_le;
      logic       prev_adj;
      logic       next_adj;
      logic       rem_more;
      logic       ins_more;
      logic       table_full;
   } stat_type;
endpackage

FILE: sv/ffa_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module ffa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_ff <= mem_ff[addr];
   end

   assign rd_data = rd_ff;
endmodule

FILE: sv/ffa_datapath.sv
// Datapath: region memories, index registers, totals and result registers.
// Depends on ffa_pkg and ffa_ram.
module ffa_datapath #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ffa_pkg::cmd_type     cmd,
   input  logic                 req_operation,
   input  logic                 req_round_to_page,
   input  logic [31:0]          req_size,
   input  logic [31:0]          req_address,
   output ffa_pkg::stat_type    stat,
   output logic [31:0]          rsp_result_address,
   output logic [1:0]           rsp_status,
   output logic [31:0]          rsp_free_total,
   output logic [31:0]          rsp_lost_count,
   output logic [31:0]          rsp_lost_size
);
   import ffa_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = AW + 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   logic          op_ff, op_in;
   logic [32:0]   want_ff, want_in;
   logic [31:0]   addr_ff, addr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [31:0]   prv_s_ff, prv_s_in, prv_l_ff, prv_l_in;
   logic [31:0]   nxt_s_ff, nxt_s_in, nxt_l_ff, nxt_l_in;
   logic [31:0]   tot_ff, tot_in, lcnt_ff, lcnt_in, lsz_ff, lsz_in;
   logic [31:0]   res_ff, res_in;
   logic [1:0]    sts_ff, sts_in;

   logic          wr_en;
   logic [AW-1:0] ram_addr;
   logic [31:0]   wr_s, wr_l, rd_s, rd_l;
   logic [32:0]   rounded;
   logic [32:0]   room;
   logic [31:0]   sz32;
   logic [32:0]   end33;
   logic [32:0]   prv_end;

   ffa_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_start (
      .clock(clock), .wr_en(wr_en), .addr(ram_addr), .wr_data(wr_s), .rd_data(rd_s));
   ffa_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_len (
      .clock(clock), .wr_en(wr_en), .addr(ram_addr), .wr_data(wr_l), .rd_data(rd_l));

   // rounding is done on 33 bits; a free is clipped at the top of memory
   assign rounded = req_round_to_page ?
                    (({1'b0, req_size} + {1'b0, PAGE_MASK_LOW}) & {1'b1, PAGE_MASK_HIGH}) :
                    {1'b0, req_size};
   assign room    = {1'b0, TOP_ADDRESS} - {1'b0, req_address};
   assign sz32    = want_ff[31:0];
   assign end33   = {1'b0, addr_ff} + {1'b0, sz32};
   assign prv_end = {1'b0, prv_s_ff} + {1'b0, prv_l_ff};

   always_comb begin
      stat.is_free    = op_ff;
      stat.size_zero  = (want_ff == 33'd0);
      stat.idx_lt_cnt = (idx_ff < cnt_ff);
      stat.fits       = ({1'b0, rd_l} >= want_ff);
      stat.len_zero   = (rd_l == sz32);
      stat.start_le   = (rd_s <= addr_ff);
      stat.prev_adj   = (idx_ff != '0) && (prv_end == {1'b0, addr_ff});
      stat.next_adj   = (idx_ff < cnt_ff) && (end33 == {1'b0, nxt_s_ff});
      stat.rem_more   = ((ptr_ff + CW'(1)) < cnt_ff);
      stat.ins_more   = (ptr_ff > idx_ff);
      stat.table_full = (cnt_ff >= DEPTH_C);
   end

   always_comb begin
      op_in = op_ff; want_in = want_ff; addr_in = addr_ff; cnt_in = cnt_ff;
      idx_in = idx_ff; ptr_in = ptr_ff; prv_s_in = prv_s_ff; prv_l_in = prv_l_ff;
      nxt_s_in = nxt_s_ff; nxt_l_in = nxt_l_ff; tot_in = tot_ff;
      lcnt_in = lcnt_ff; lsz_in = lsz_ff; res_in = res_ff; sts_in = sts_ff;
      wr_en = 1'b0; ram_addr = idx_ff[AW-1:0]; wr_s = addr_ff; wr_l = sz32;
      case (cmd)
         CMD_LOAD: begin
            op_in   = req_operation;
            addr_in = req_address;
            if (req_operation == OP_FREE && rounded > room) begin
               want_in = room;
            end else begin
               want_in = rounded;
            end
            idx_in = '0;
            res_in = '0;
            sts_in = ST_OK;
         end
         CMD_RD_IDX: ram_addr = idx_ff[AW-1:0];
         CMD_IDX_INC: idx_in = idx_ff + CW'(1);
         CMD_ALLOC_WR: begin
            wr_en  = 1'b1;
            wr_s   = rd_s + sz32;
            wr_l   = rd_l - sz32;
            res_in = rd_s;
            tot_in = tot_ff - sz32;
            ptr_in = idx_ff;
         end
         CMD_NOFIT: sts_in = ST_NOFIT;
         CMD_SAVE_PREV: begin
            prv_s_in = rd_s; prv_l_in = rd_l;
            idx_in = idx_ff + CW'(1);
         end
         CMD_SAVE_NEXT: begin
            nxt_s_in = rd_s; nxt_l_in = rd_l;
         end
         CMD_MERGE_PREV: begin
            wr_en = 1'b1; ram_addr = AW'(idx_ff - CW'(1));
            wr_s = prv_s_ff; wr_l = prv_l_ff + sz32;
            tot_in = tot_ff + sz32;
         end
         CMD_MERGE_BOTH: begin
            wr_en = 1'b1; ram_addr = AW'(idx_ff - CW'(1));
            wr_s = prv_s_ff; wr_l = prv_l_ff + sz32 + nxt_l_ff;
            tot_in = tot_ff + sz32;
            ptr_in = idx_ff;
         end
         CMD_MERGE_NEXT: begin
            wr_en = 1'b1; ram_addr = idx_ff[AW-1:0];
            wr_s = addr_ff; wr_l = nxt_l_ff + sz32;
            tot_in = tot_ff + sz32;
         end
         CMD_INS_SETUP: ptr_in = cnt_ff;
         CMD_INS_RD: ram_addr = AW'(ptr_ff - CW'(1));
         CMD_INS_WR: begin
            wr_en = 1'b1; ram_addr = ptr_ff[AW-1:0]; wr_s = rd_s; wr_l = rd_l;
            ptr_in = ptr_ff - CW'(1);
         end
         CMD_INS_NEW: begin
            wr_en = 1'b1; ram_addr = idx_ff[AW-1:0]; wr_s = addr_ff; wr_l = sz32;
            cnt_in = cnt_ff + CW'(1);
            tot_in = tot_ff + sz32;
         end
         CMD_REM_RD: ram_addr = AW'(ptr_ff + CW'(1));
         CMD_REM_WR: begin
            wr_en = 1'b1; ram_addr = ptr_ff[AW-1:0]; wr_s = rd_s; wr_l = rd_l;
            ptr_in = ptr_ff + CW'(1);
         end
         CMD_REM_DONE: cnt_in = cnt_ff - CW'(1);
         CMD_LOST: begin
            lcnt_in = lcnt_ff + 32'd1; lsz_in = lsz_ff + sz32; sts_in = ST_LOST;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0; tot_ff <= '0; lcnt_ff <= '0; lsz_ff <= '0;
      end else begin
         cnt_ff <= cnt_in; tot_ff <= tot_in; lcnt_ff <= lcnt_in; lsz_ff <= lsz_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; want_ff <= want_in; addr_ff <= addr_in;
      idx_ff <= idx_in; ptr_ff <= ptr_in;
      prv_s_ff <= prv_s_in; prv_l_ff <= prv_l_in;
      nxt_s_ff <= nxt_s_in; nxt_l_ff <= nxt_l_in;
      res_ff <= res_in; sts_ff <= sts_in;
   end

   assign rsp_result_address = res_ff;
   assign rsp_status         = sts_ff;
   assign rsp_free_total     = tot_ff;
   assign rsp_lost_count     = lcnt_ff;
   assign rsp_lost_size      = lsz_ff;
endmodule

FILE: sv/ffa_ctrl.sv
// Controller state machine for the allocator.
// Depends on ffa_pkg and the assertion macro header.
`include "first_fit_free_list_allocator_top_macros.svh"
module ffa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  ffa_pkg::stat_type stat,
   output ffa_pkg::cmd_type  cmd
);
   import ffa_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:     if (req_valid) state_in = S_DISPATCH;
         S_DISPATCH: begin
            if (!stat.is_free) state_in = S_A_RD;
            else if (stat.size_zero) state_in = S_RESP;
            else state_in = S_F_RD;
         end
         S_A_RD:     state_in = stat.idx_lt_cnt ? S_A_CHK : S_RESP;
         S_A_CHK: begin
            if (!stat.fits) state_in = S_A_RD;
            else if (stat.len_zero) state_in = S_R_CHK;
            else state_in = S_RESP;
         end
         S_R_CHK:    state_in = stat.rem_more ? S_R_WR : S_RESP;
         S_R_WR:     state_in = S_R_CHK;
         S_F_RD:     state_in = stat.idx_lt_cnt ? S_F_CHK : S_F_DECIDE;
         S_F_CHK:    state_in = stat.start_le ? S_F_RD : S_F_DECIDE;
         S_F_DECIDE: begin
            if (stat.prev_adj) state_in = stat.next_adj ? S_R_CHK : S_RESP;
            else if (stat.next_adj) state_in = S_RESP;
            else if (!stat.table_full) state_in = S_I_CHK;
            else state_in = S_RESP;
         end
         S_I_CHK:    state_in = stat.ins_more ? S_I_WR : S_I_NEW;
         S_I_WR:     state_in = S_I_CHK;
         S_I_NEW:    state_in = S_RESP;
         S_RESP:     if (rsp_ready) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = CMD_NONE;
      req_ready = (state_ff == S_IDLE);
      rsp_valid = (state_ff == S_RESP);
      case (state_ff)
         S_IDLE:     if (req_valid) cmd = CMD_LOAD;
         S_A_RD:     cmd = stat.idx_lt_cnt ? CMD_RD_IDX : CMD_NOFIT;
         S_A_CHK:    cmd = stat.fits ? CMD_ALLOC_WR : CMD_IDX_INC;
         S_R_CHK:    cmd = stat.rem_more ? CMD_REM_RD : CMD_REM_DONE;
         S_R_WR:     cmd = CMD_REM_WR;
         S_F_RD:     if (stat.idx_lt_cnt) cmd = CMD_RD_IDX;
         S_F_CHK:    cmd = stat.start_le ? CMD_SAVE_PREV : CMD_SAVE_NEXT;
         S_F_DECIDE: begin
            if (stat.prev_adj) cmd = stat.next_adj ? CMD_MERGE_BOTH : CMD_MERGE_PREV;
            else if (stat.next_adj) cmd = CMD_MERGE_NEXT;
            else if (!stat.table_full) cmd = CMD_INS_SETUP;
            else cmd = CMD_LOST;
         end
         S_I_CHK:    if (stat.ins_more) cmd = CMD_INS_RD;
         S_I_WR:     cmd = CMD_INS_WR;
         S_I_NEW:    cmd = CMD_INS_NEW;
         default:    cmd = CMD_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `FFA_ASSERT_IMPL(a_one_side, clock, reset, !(req_ready && rsp_valid))
   `FFA_ASSERT_IMPL(a_resp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> rsp_valid)
   `FFA_ASSERT_IMPL(a_accept_leaves, clock, reset, (req_valid && req_ready) |=> !req_ready)
endmodule

FILE: sv/first_fit_free_list_allocator_top.sv
// First-fit free-list allocator with coalescing, one request at a time.
// The response follows the request transfer after a scan of the table entries and, for
// an insert or a removal, a shift of the entries behind that slot.
// A new request is not taken until the result of the last one is transferred;
// the next request is taken in the cycle after the result transfer.
// Reset clears the region count and totals; memories are not cleared.
`include "first_fit_free_list_allocator_top_macros.svh"
module first_fit_free_list_allocator_top #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic        req_round_to_page,
   input  logic [31:0] req_size,
   input  logic [31:0] req_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_result_address,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_free_total,
   output logic [31:0] rsp_lost_count,
   output logic [31:0] rsp_lost_size
);
   import ffa_pkg::*;

   stat_type stat;
   cmd_type  cmd;

   ffa_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .stat(stat), .cmd(cmd));

   ffa_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .req_operation(req_operation),
      .req_round_to_page(req_round_to_page), .req_size(req_size),
      .req_address(req_address), .stat(stat),
      .rsp_result_address(rsp_result_address), .rsp_status(rsp_status),
      .rsp_free_total(rsp_free_total), .rsp_lost_count(rsp_lost_count),
      .rsp_lost_size(rsp_lost_size));

   `FFA_ASSERT_IMPL(a_status_code, clock, reset, rsp_valid |-> (rsp_status != 2'b11))
   `FFA_ASSERT_IMPL(a_fail_zero, clock, reset, (rsp_valid && rsp_status == ST_NOFIT) |-> (rsp_result_address == 32'd0))
   `FFA_ASSERT_NORST(a_reset_idle, clock, $past(reset) |-> !rsp_valid)
endmodule
